// File: design/assert_macros.svh
// Assertion macros for the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: design/ptw_pkg.sv
// Shared constants, types and helpers for the page table walker.
// No dependencies; imported by every module of the block except ptw_ram.
package ptw_pkg;

    // Table geometry.
    localparam int FRAMES   = 64;
    localparam int LEVELS   = 5;
    localparam int SLOT_W   = 9;
    localparam int SLOTS    = 1 << SLOT_W;
    localparam int NUM_W    = 52;
    localparam int ENTRY_W  = NUM_W + 1;
    localparam int DEPTH    = FRAMES * SLOTS;
    localparam int FRAME_W  = $clog2(FRAMES);
    localparam int ADDR_W   = FRAME_W + SLOT_W;
    localparam int VA_W     = LEVELS * SLOT_W;
    localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ALLOC_W  = $clog2(FRAMES + 1);

    // Field and register widths.
    localparam int VPN_W    = 64;
    localparam int ROOT_W   = 6;
    localparam int FREE_W   = 7;
    localparam int NF_W     = ((ALLOC_W > FREE_W) ? ALLOC_W : FREE_W) + 1;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int STATUS_W = 2;

    // Stream packing.
    localparam int IN_TDATA_W  = 120;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 56;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROOT       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_FREE = 1'b1;

    // Operation codes.
    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_BAD_VPN   = 2'd1,
        ST_NO_FRAME  = 2'd2,
        ST_NULL_ROOT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_LEAF,
        S_FIN
    } state_t;

    typedef struct packed {
        logic             mapped;
        logic [NUM_W-1:0] ppn;
        status_t          status;
    } res_t;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [ENTRY_W-1:0] wdata;
        logic               re;
        logic [ADDR_W-1:0]  raddr;
    } mem_req_t;

    // A vpn is canonical when bits 57..63 all copy bit 56.
    function automatic logic vpn_ok(input logic [VPN_W-1:0] vpn);
        return (vpn[VPN_W-1:56] == 8'h00) || (vpn[VPN_W-1:56] == 8'hFF);
    endfunction

endpackage

// File: design/page_table_walker.sv
// Top level of the five-level page table walker: stream ports, configuration
// registers, output register. Depends on ptw_pkg, ptw_ram and ptw_walk.
//
// Usage:
//   Requests arrive on the s_ stream; each item is a query (tuser op = 0)
//   or an update (op = 1, with unmap in tuser bit 1). Exactly one result
//   item leaves on the m_ stream for each request, in order.
//   root_frame and first_free_frame must be written through cfg_wr_* only while
//   the block is idle (not enforced); a write takes effect at the next clock edge.
// Timing:
//   Each level that a walk reads is an address state, then a check of the registered
//   entry; an update writes its leaf in a leaf state. A rejected item goes straight
//   to its result, and a walk that stops at a missing table ends sooner than a full
//   one. One item is in flight at a time, so the block takes no new item until its
//   result has left the walker; walks wait on dependent reads on one memory port.
// Reset:
//   aresetn low (synchronous) clears the allocator and root frame, sets first_free
//   to 1, then the block sweeps all 32768 memory entries to zero, one per cycle,
//   with s_tready low. On a receiver stall the result waits in the output register
//   and one more finished walk waits in the walker with s_tready low.
module page_table_walker (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port.
    input  logic                               cfg_wr_en,
    input  logic [ptw_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [ptw_pkg::CFG_W-1:0]          cfg_wr_data,
    // Request stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ptw_pkg::IN_TDATA_W-1:0]     s_tdata,   // vpn[63:0], ppn[115:64]
    input  logic [ptw_pkg::IN_TUSER_W-1:0]     s_tuser,   // op[0], unmap[1]
    // Result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ptw_pkg::OUT_TDATA_W-1:0]    m_tdata    // mapped[0], ppn_out[52:1],
                                                          // status[54:53]
);
    import ptw_pkg::*;

    logic [ROOT_W-1:0]  root_frame_reg;
    logic [FREE_W-1:0]  first_free_reg;
    logic               m_tvalid_reg;
    res_t               m_res_reg;

    logic               start;
    logic               ready;
    logic               res_valid;
    logic               res_take;
    res_t               res;
    mem_req_t           mem_req;
    logic [ENTRY_W-1:0] mem_rdata;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_frame_reg <= '0;
            first_free_reg <= FREE_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_ROOT:       root_frame_reg <= cfg_wr_data[ROOT_W-1:0];
                REG_FIRST_FREE: first_free_reg <= cfg_wr_data[FREE_W-1:0];
                default:        root_frame_reg <= root_frame_reg;
            endcase
        end
    end

    assign s_tready = ready;
    assign start    = s_tvalid && ready;
    assign res_take = res_valid && (!m_tvalid_reg || m_tready);

    ptw_walk u_walk (
        .clk        (aclk),
        .rstn       (aresetn),
        .root_frame (root_frame_reg),
        .first_free (first_free_reg),
        .start      (start),
        .op         (s_tuser[0]),
        .vpn        (s_tdata[VPN_W-1:0]),
        .ppn        (s_tdata[VPN_W+NUM_W-1:VPN_W]),
        .unmap      (s_tuser[1]),
        .ready      (ready),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    ptw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    // Output register decouples the walker from a stalled receiver.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (res_take) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_res_reg.status, m_res_reg.ppn, m_res_reg.mapped};

endmodule

// File: design/ptw_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ptw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/ptw_walk.sv
// Walk sequencer: clears the table memory after reset, then walks, allocates
// and writes table entries one memory access at a time. Depends on ptw_pkg.
module ptw_walk (
    input  logic                          clk,
    input  logic                          rstn,
    input  logic [ptw_pkg::ROOT_W-1:0]    root_frame,
    input  logic [ptw_pkg::FREE_W-1:0]    first_free,
    input  logic                          start,
    input  logic                          op,
    input  logic [ptw_pkg::VPN_W-1:0]     vpn,
    input  logic [ptw_pkg::NUM_W-1:0]     ppn,
    input  logic                          unmap,
    output logic                          ready,
    output logic                          res_valid,
    input  logic                          res_take,
    output ptw_pkg::res_t                 res,
    output ptw_pkg::mem_req_t             mem_req,
    input  logic [ptw_pkg::ENTRY_W-1:0]   mem_rdata
);
    import ptw_pkg::*;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg;
    logic [ALLOC_W-1:0]   alloc_reg;
    logic                 op_reg;
    logic                 unmap_reg;
    logic [VA_W-1:0]      va_reg;
    logic [NUM_W-1:0]     ppn_reg;
    logic [NUM_W-1:0]     frame_reg;
    logic [LVL_W-1:0]     lvl_reg;
    res_t                 res_reg;

    logic                 frame_oob;
    logic [SLOT_W-1:0]    slot;
    logic [ADDR_W-1:0]    addr;
    logic [ENTRY_W-1:0]   entry;
    logic                 e_valid;
    logic [NUM_W-1:0]     e_num;
    logic [NF_W-1:0]      nf;
    logic                 nf_full;
    logic                 do_alloc;
    logic                 start_bad;
    logic                 start_null;

    // Address of the current entry; frames past the memory read as empty.
    assign frame_oob = frame_reg >= NUM_W'(FRAMES);
    assign slot      = va_reg[SLOT_W*lvl_reg +: SLOT_W];
    assign addr      = {frame_reg[FRAME_W-1:0], slot};
    assign entry     = frame_oob ? '0 : mem_rdata;
    assign e_valid   = entry[NUM_W];
    assign e_num     = entry[NUM_W-1:0];

    // Bump allocator.
    assign nf       = NF_W'(first_free) + NF_W'(alloc_reg);
    assign nf_full  = nf >= NF_W'(FRAMES);
    assign do_alloc = (op_reg == OP_UPDATE) && !e_valid && !unmap_reg && !nf_full;

    // Early outcomes decided when an item arrives.
    assign start_bad  = !vpn_ok(vpn);
    assign start_null = (op == OP_UPDATE) && (root_frame == '0);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (start_bad || start_null) begin
                        state_next = S_FIN;
                    end else if (op == OP_UPDATE && LEVELS == 1) begin
                        state_next = S_LEAF;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (op_reg == OP_QUERY) begin
                    if (!e_valid || lvl_reg == '0) begin
                        state_next = S_FIN;
                    end else begin
                        state_next = S_READ;
                    end
                end else if (!e_valid && (unmap_reg || nf_full)) begin
                    state_next = S_FIN;
                end else if (lvl_reg == LVL_W'(1)) begin
                    state_next = S_LEAF;
                end else begin
                    state_next = S_READ;
                end
            end
            S_LEAF: begin
                state_next = S_FIN;
            end
            S_FIN: begin
                if (res_take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Memory requests and handshake outputs.
    always_comb begin
        mem_req   = '0;
        ready     = 1'b0;
        res_valid = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_cnt_reg;
            end
            S_IDLE: begin
                ready = 1'b1;
            end
            S_READ: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = addr;
            end
            S_CHECK: begin
                mem_req.we    = do_alloc && !frame_oob;
                mem_req.waddr = addr;
                mem_req.wdata = {1'b1, NUM_W'(nf)};
            end
            S_LEAF: begin
                mem_req.we    = !frame_oob;
                mem_req.waddr = addr;
                mem_req.wdata = unmap_reg ? '0 : {1'b1, ppn_reg};
            end
            S_FIN: begin
                res_valid = 1'b1;
            end
            default: begin
                mem_req = '0;
            end
        endcase
    end

    assign res = res_reg;

    // Walk registers.
    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            alloc_reg   <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
                S_IDLE: begin
                    if (start) begin
                        op_reg         <= op;
                        unmap_reg      <= unmap;
                        va_reg         <= vpn[VA_W-1:0];
                        ppn_reg        <= ppn;
                        frame_reg      <= NUM_W'(root_frame);
                        lvl_reg        <= LVL_W'(LEVELS - 1);
                        res_reg.mapped <= 1'b0;
                        res_reg.ppn    <= '0;
                        if (start_bad) begin
                            res_reg.status <= ST_BAD_VPN;
                        end else if (start_null) begin
                            res_reg.status <= ST_NULL_ROOT;
                        end else begin
                            res_reg.status <= ST_DONE;
                        end
                    end
                end
                S_CHECK: begin
                    if (do_alloc) begin
                        alloc_reg <= alloc_reg + 1'b1;
                        frame_reg <= NUM_W'(nf);
                    end else begin
                        frame_reg <= e_num;
                    end
                    if (lvl_reg != '0) begin
                        lvl_reg <= lvl_reg - 1'b1;
                    end
                    // A query that reaches a valid leaf returns its page.
                    if (op_reg == OP_QUERY && e_valid && lvl_reg == '0) begin
                        res_reg.mapped <= 1'b1;
                        res_reg.ppn    <= e_num;
                    end
                    if (op_reg == OP_UPDATE && !e_valid && !unmap_reg && nf_full) begin
                        res_reg.status <= ST_NO_FRAME;
                    end
                end
                default: begin
                    clr_cnt_reg <= clr_cnt_reg;
                end
            endcase
        end
    end

endmodule

// File: design/ptw_checker.sv
// Port-level checks for the page table walker, bound to the top level.
// Depends on ptw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptw_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ptw_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import ptw_pkg::*;

    // The memory clearing sweep follows every reset, so no item is taken.
    `ASSERT_SAME(a_clear_after_reset, aclk, aresetn, $past(!aresetn), !s_tready)

    // One item at a time: an accepted item closes the input side.
    `ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // A new result only appears once the input side has been closed.
    `ASSERT_SAME(a_result_after_walk, aclk, aresetn, $rose(m_tvalid), $past(!s_tready))

    // A stalled result item holds.
    `ASSERT_NEXT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready,
                 m_tvalid && $stable(m_tdata))

endmodule

bind page_table_walker ptw_checker u_ptw_checker (.*);

// File: verif/page_table_walker_tb.sv
// Self-checking testbench for page_table_walker: drives request items on the s_ stream,
// predicts every table walk and compares each result item on the m_ stream.
// Depends on ptw_pkg and the page_table_walker RTL only.
`timescale 1ns / 1ps

module page_table_walker_tb;
    import ptw_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 20;
    localparam int POOL_SIZE    = 6;

    // Tracks the table memory, the allocator and the registers, and queues the
    // result expected for each accepted request item.
    class ptw_scoreboard;
        bit [ENTRY_W-1:0] table_copy [DEPTH];
        int unsigned      frames_taken;
        bit [ROOT_W-1:0]  root_reg;
        bit [FREE_W-1:0]  free_base;
        res_t             expected_results [$];
        int               mismatches;

        function new();
            frames_taken = 0;
            root_reg     = '0;
            free_base    = FREE_W'(1);
            mismatches   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_ROOT) root_reg = val[ROOT_W-1:0];
            else free_base = val[FREE_W-1:0];
        endfunction

        // Frames past the end of the memory read as empty and swallow writes.
        function bit [ENTRY_W-1:0] fetch(bit [NUM_W-1:0] frame, bit [SLOT_W-1:0] slot);
            if (frame >= FRAMES) return '0;
            return table_copy[{frame[FRAME_W-1:0], slot}];
        endfunction

        function void store(bit [NUM_W-1:0] frame, bit [SLOT_W-1:0] slot,
                            bit [ENTRY_W-1:0] entry);
            if (frame < FRAMES) table_copy[{frame[FRAME_W-1:0], slot}] = entry;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Walks the tables for one accepted request and queues its result.
        function void note_request(logic op, logic [VPN_W-1:0] vpn, logic [NUM_W-1:0] ppn,
                                   logic unmap);
            res_t             r;
            bit [NUM_W-1:0]   frame;
            bit [ENTRY_W-1:0] entry;
            bit [SLOT_W-1:0]  slot;
            bit               going;
            int               lvl;
            int unsigned      next_frame;

            r.mapped = 1'b0;
            r.ppn    = '0;
            r.status = ST_DONE;
            frame    = NUM_W'(root_reg);
            going    = 1'b1;

            if (vpn[63:57] != {7{vpn[56]}}) begin
                r.status = ST_BAD_VPN;
            end else if (op == OP_QUERY) begin
                for (lvl = LEVELS - 1; lvl >= 0 && going; lvl--) begin
                    entry = fetch(frame, vpn[SLOT_W*lvl +: SLOT_W]);
                    if (!entry[NUM_W]) going = 1'b0;
                    else frame = entry[NUM_W-1:0];
                end
                if (going) begin
                    r.mapped = 1'b1;
                    r.ppn    = frame;
                end
            end else if (root_reg == 0) begin
                r.status = ST_NULL_ROOT;
            end else begin
                // Upper levels: take missing tables from the bump allocator when mapping.
                for (lvl = LEVELS - 1; lvl > 0 && going; lvl--) begin
                    slot  = vpn[SLOT_W*lvl +: SLOT_W];
                    entry = fetch(frame, slot);
                    if (!entry[NUM_W]) begin
                        next_frame = free_base + frames_taken;
                        if (unmap) begin
                            going = 1'b0;
                        end else if (next_frame >= FRAMES) begin
                            r.status = ST_NO_FRAME;
                            going    = 1'b0;
                        end else begin
                            frames_taken++;
                            entry = {1'b1, NUM_W'(next_frame)};
                            store(frame, slot, entry);
                        end
                    end
                    if (going) frame = entry[NUM_W-1:0];
                end
                if (going) store(frame, vpn[SLOT_W-1:0], unmap ? '0 : {1'b1, ppn});
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] d);
            res_t                want;
            logic                got_mapped;
            logic [NUM_W-1:0]    got_ppn;
            logic [STATUS_W-1:0] got_status;

            got_mapped = d[0];
            got_ppn    = d[NUM_W:1];
            got_status = d[NUM_W+STATUS_W:NUM_W+1];
            if (expected_results.size() == 0) begin
                $error("result item with no request waiting: tdata %h", d);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (got_mapped !== want.mapped) begin
                $error("mapped mismatch: expected %0d, got %0d", want.mapped, got_mapped);
                mismatches++;
            end
            if (got_ppn !== want.ppn) begin
                $error("ppn_out mismatch: expected %h, got %h", want.ppn, got_ppn);
                mismatches++;
            end
            if (got_status !== want.status) begin
                $error("status mismatch: expected %0d, got %0d", want.status, got_status);
                mismatches++;
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_wr_index = '0;
    logic [CFG_W-1:0]       cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;    // vpn[63:0], ppn[115:64]
    logic [IN_TUSER_W-1:0]  s_tuser = '0;    // op[0], unmap[1]
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // mapped[0], ppn_out[52:1], status[54:53]

    ptw_scoreboard sb = new();

    int          burst_left = 0;
    int          hold_requested = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          rx_mode = 0;
    int          rx_left = 0;
    int unsigned rx_phase = 0;
    int unsigned cycles = 0;
    logic [35:0] path_pool [POOL_SIZE];

    page_table_walker DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Give up if the run hangs.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Handshake monitor: results are checked before the same edge's request is noted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser[0], s_tdata[VPN_W-1:0],
                                s_tdata[VPN_W+NUM_W-1:VPN_W], s_tuser[1]);
        end
    end

    // Result receiver: switches between stall patterns, plus a long hold-off on request.
    always @(negedge aclk) begin
        if (hold_requested != hold_served) begin
            hold_served = hold_requested;
            hold_left   = 400;
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 80);
        end
        rx_left--;
        rx_phase++;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                2: m_tready <= (rx_phase % 4 == 0);
                default: m_tready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // Offers one request item; the sender works in bursts, mostly separated by random gaps.
    task automatic send_item(input logic op, input logic [VPN_W-1:0] vpn,
                             input logic [NUM_W-1:0] ppn, input logic unmap);
        int gap;

        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - VPN_W - NUM_W){1'b0}}, ppn, vpn};
        s_tuser  <= {unmap, op};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops offering and waits until every result has come back.
    task automatic drain();
        @(negedge aclk);
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic reconfigure(input int root, input int free);
        drain();
        write_reg(REG_ROOT, CFG_W'(root));
        write_reg(REG_FIRST_FREE, CFG_W'(free));
    endtask

    // Builds a canonical vpn: bits 45..56 are random and bits 57..63 copy bit 56.
    function automatic logic [VPN_W-1:0] canon_vpn(logic [35:0] upper, logic [8:0] low);
        logic [11:0] unused_bits;

        unused_bits = 12'($urandom);
        return {{7{unused_bits[11]}}, unused_bits, upper, low};
    endfunction

    function automatic logic [NUM_W-1:0] rand_ppn();
        if ($urandom_range(0, 9) < 3) return NUM_W'($urandom_range(0, FRAMES - 1));
        return NUM_W'({$urandom, $urandom});
    endfunction

    // Mostly walks over a few known paths; some fresh paths and malformed vpns as noise.
    task automatic random_request();
        int               roll;
        logic [VPN_W-1:0] vpn;
        logic [8:0]       low;
        logic             op;
        logic             unmap;

        roll  = $urandom_range(0, 99);
        unmap = 1'b0;
        if (roll < 5) begin
            vpn = {$urandom, $urandom};
            if (vpn[63:57] == {7{vpn[56]}}) vpn[60] = ~vpn[60];
            op    = 1'($urandom_range(0, 1));
            unmap = 1'($urandom_range(0, 1));
        end else if (roll < 10) begin
            vpn   = canon_vpn(36'({$urandom, $urandom}), 9'($urandom));
            op    = 1'($urandom_range(0, 1));
            unmap = 1'($urandom_range(0, 1));
        end else begin
            low  = ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 7));
            vpn  = canon_vpn(path_pool[$urandom_range(0, POOL_SIZE - 1)], low);
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                op    = OP_QUERY;
                unmap = 1'($urandom_range(0, 1));
            end else begin
                op    = OP_UPDATE;
                unmap = (roll >= 85);
            end
        end
        send_item(op, vpn, rand_ppn(), unmap);
    endtask

    task automatic random_items(input int n);
        repeat (n) random_request();
    endtask

    initial begin
        path_pool[0] = '0;
        path_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) path_pool[i] = 36'({$urandom, $urandom});

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset register values: root frame 0 is walked by queries, refused on updates.
        send_item(OP_QUERY, 64'h0, '1, 1'b0);
        send_item(OP_UPDATE, 64'h0, '1, 1'b0);
        send_item(OP_UPDATE, 64'h0, '0, 1'b1);
        send_item(OP_QUERY, 64'h0100_0000_0000_0000, '0, 1'b0);
        send_item(OP_UPDATE, 64'h8000_0000_0000_0000, '1, 1'b0);
        send_item(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b1);
        send_item(OP_UPDATE, 64'h00FF_FFFF_FFFF_FFFF, '1, 1'b0);

        // Root 1, allocation from frame 2: the first map builds frames 2 to 5,
        // with frame 5 as the leaf table of vpn 0.
        reconfigure(1, 2);
        send_item(OP_UPDATE, 64'h0, '1, 1'b0);
        send_item(OP_QUERY, 64'h0, '0, 1'b0);
        send_item(OP_UPDATE, 64'h1, 52'd3, 1'b0);
        send_item(OP_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0);
        send_item(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, '1, 1'b0);
        send_item(OP_UPDATE, 64'h0000_1234_5678_9ABC, '1, 1'b1);
        send_item(OP_QUERY, 64'h0000_1234_5678_9ABC, '0, 1'b0);
        send_item(OP_UPDATE, 64'h0, '0, 1'b1);
        send_item(OP_QUERY, 64'h0, '0, 1'b0);
        send_item(OP_UPDATE, 64'h7F00_0000_0000_0001, '1, 1'b0);
        send_item(OP_UPDATE, 64'h0, '1, 1'b0);
        hold_requested++;
        random_items(600);

        // Allocator pointed past the last frame: every missing table fails.
        reconfigure(FRAMES - 1, FRAMES);
        send_item(OP_UPDATE, 64'h0000_0ABC_DEF0_1234, '1, 1'b0);
        send_item(OP_QUERY, 64'h0000_0ABC_DEF0_1234, '0, 1'b0);
        random_items(200);

        // Root on a leaf table: entries are page numbers, often beyond the memory.
        reconfigure(5, 2);
        send_item(OP_QUERY, 64'h0, '0, 1'b0);
        send_item(OP_UPDATE, 64'h0, 52'h5A5A5, 1'b0);
        random_items(200);

        // Allocator base at frame 0 on top of frames already taken, which may reuse live tables.
        reconfigure(FRAMES - 1, 0);
        random_items(350);

        // Back to a null root.
        reconfigure(0, 1);
        random_items(200);

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/ptw_pkg.sv
design/ptw_ram.sv
design/ptw_walk.sv
design/page_table_walker.sv
design/ptw_checker.sv
verif/page_table_walker_tb.sv
